/* rtl/gbts_pkg.sv */
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared field widths and operation/status codes for the gap-buffer text store.
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

    localparam int FUNC_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 13;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADRANGE = 2'd2;

endpackage

`default_nettype wire

/* rtl/gbts_if.sv */
// ----------------------------------------------------------------------------
// gbts_if
// Command and response channels of the gap-buffer text store.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbts_cmd_if
    import gbts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  end_position;

    modport source (output valid, func, char_in, position, end_position, input ready);
    modport sink   (input valid, func, char_in, position, end_position, output ready);
endinterface

interface gbts_rsp_if
    import gbts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   char_out;
    logic [POS_W-1:0]    cursor;
    logic [POS_W-1:0]    text_length;
    logic [STATUS_W-1:0] status;

    modport source (output valid, char_out, cursor, text_length, status, input ready);
    modport sink   (input valid, char_out, cursor, text_length, status, output ready);
endinterface

`default_nettype wire

/* rtl/gbts_mem.sv */
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store with one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_mem
    import gbts_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CHAR_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a read of the address being written sees the new byte
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/gap_buffer_text_store_core.sv */
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Gap-buffer text store: insert, delete range, move cursor, read, clear.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | transfer
//  cmd     | in  | func, char_in, position, end_position         | valid & ready
//  rsp     | out | char_out, cursor, text_length, status         | valid & ready
//
//  insert, clear, a read past the end and rejected or empty requests go from
//  decode straight to finish; a read in range passes S_READ for the registered
//  read data; move and delete first walk the gap to the target, delete then
//  widens it; the single port pair copies one byte per cycle across the gap.
//  cmd.ready is high only while the sequencer is idle; a finished response
//  waits in the output register, and a new command is taken meanwhile.
//  rst_n clears cursor and gap; store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store_core
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gbts_cmd_if.sink    cmd,
    gbts_rsp_if.source  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int XW = ((PW > POS_W) ? PW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_DELETE,
        S_READ,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       gs_reg, gs_next;
    logic [PW-1:0]       ge_reg, ge_next;
    logic [PW-1:0]       target_reg, target_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    endp_reg, endp_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0]   rd_char_reg, rd_char_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [CHAR_W-1:0]   char_out_reg, char_out_next;
    logic [POS_W-1:0]    cursor_reg, cursor_next;
    logic [POS_W-1:0]    len_out_reg, len_out_next;
    logic [STATUS_W-1:0] status_out_reg, status_out_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [CHAR_W-1:0]   mem_rdata;

    logic [PW-1:0]       len;
    logic [PW-1:0]       gs_dec, ge_dec;
    logic [XW-1:0]       len_x, gs_x, ge_x, pos_x, endp_x, cap_x;
    logic [XW-1:0]       rd_idx_x, del_end_x;

    gbts_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign len      = PW'(CAPACITY) - (ge_reg - gs_reg);
    assign gs_dec   = gs_reg - PW'(1);
    assign ge_dec   = ge_reg - PW'(1);
    assign len_x    = XW'(len);
    assign gs_x     = XW'(gs_reg);
    assign ge_x     = XW'(ge_reg);
    assign pos_x    = XW'(pos_reg);
    assign endp_x   = XW'(endp_reg);
    assign cap_x    = XW'(CAPACITY);
    // text position to store index across the gap
    assign rd_idx_x  = (pos_x < gs_x) ? pos_x : (ge_x + pos_x - gs_x);
    assign del_end_x = ge_x + (endp_x - pos_x);

    always_comb
    begin
        state_next      = state_reg;
        gs_next         = gs_reg;
        ge_next         = ge_reg;
        target_next     = target_reg;
        func_next       = func_reg;
        char_next       = char_reg;
        pos_next        = pos_reg;
        endp_next       = endp_reg;
        status_next     = status_reg;
        rd_char_next    = rd_char_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        char_out_next   = char_out_reg;
        cursor_next     = cursor_reg;
        len_out_next    = len_out_reg;
        status_out_next = status_out_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = rd_idx_x[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = cmd.func;
                    char_next  = cmd.char_in;
                    pos_next   = cmd.position;
                    endp_next  = cmd.end_position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next  = ST_DONE;
                rd_char_next = '0;
                state_next   = S_FINISH;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (gs_reg == ge_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = gs_reg[AW-1:0];
                            mem_wdata = char_reg;
                            gs_next   = gs_reg + PW'(1);
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (pos_x < endp_x)
                        begin
                            if (pos_x > len_x)
                            begin
                                status_next = ST_BADRANGE;
                            end
                            else
                            begin
                                target_next = pos_x[PW-1:0];
                                state_next  = S_SHIFT;
                            end
                        end
                    end
                    FUNC_MOVE:
                    begin
                        target_next = (pos_x > len_x) ? len : pos_x[PW-1:0];
                        state_next  = S_SHIFT;
                    end
                    FUNC_READ:
                    begin
                        if (pos_x < len_x)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = rd_idx_x[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        gs_next = '0;
                        ge_next = PW'(CAPACITY);
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end

            // one byte copied per cycle; each write lands in the cycle after its read
            S_SHIFT:
            begin
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = mem_rdata;
                if (target_reg < gs_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = gs_dec[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = ge_dec[AW-1:0];
                    gs_next      = gs_dec;
                    ge_next      = ge_dec;
                end
                else if (target_reg > gs_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = ge_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = gs_reg[AW-1:0];
                    gs_next      = gs_reg + PW'(1);
                    ge_next      = ge_reg + PW'(1);
                end
                else
                begin
                    state_next = (func_reg == FUNC_DELETE) ? S_DELETE : S_FINISH;
                end
            end

            S_DELETE:
            begin
                if (del_end_x > cap_x)
                begin
                    status_next = ST_BADRANGE;
                end
                else
                begin
                    ge_next = del_end_x[PW-1:0];
                end
                state_next = S_FINISH;
            end

            S_READ:
            begin
                rd_char_next = mem_rdata;
                state_next   = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    char_out_next   = rd_char_reg;
                    cursor_next     = gs_x[POS_W-1:0];
                    len_out_next    = len_x[POS_W-1:0];
                    status_out_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gs_reg        <= '0;
            ge_reg        <= PW'(CAPACITY);
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            ge_reg        <= ge_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        func_reg       <= func_next;
        char_reg       <= char_next;
        pos_reg        <= pos_next;
        endp_reg       <= endp_next;
        status_reg     <= status_next;
        rd_char_reg    <= rd_char_next;
        wr_addr_reg    <= wr_addr_next;
        char_out_reg   <= char_out_next;
        cursor_reg     <= cursor_next;
        len_out_reg    <= len_out_next;
        status_out_reg <= status_out_next;
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.char_out    = char_out_reg;
    assign rsp.cursor      = cursor_reg;
    assign rsp.text_length = len_out_reg;
    assign rsp.status      = status_out_reg;

endmodule

`default_nettype wire

/* rtl/gbts_checker.sv */
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks on the gap-buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_checker
    import gbts_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cmd_valid,
    input wire logic                cmd_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [CHAR_W-1:0]   rsp_char_out,
    input wire logic [POS_W-1:0]    rsp_cursor,
    input wire logic [POS_W-1:0]    rsp_text_length,
    input wire logic [STATUS_W-1:0] rsp_status
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out)
            && $stable(rsp_cursor) && $stable(rsp_text_length) && $stable(rsp_status))
        else $error("response changed while stalled");

    // one command at a time: busy right after a transfer
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_DONE) || (rsp_status == ST_FULL)
            || (rsp_status == ST_BADRANGE))
        else $error("unknown status code");

    // a rejected insert carries no read byte
    a_full_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> rsp_char_out == '0)
        else $error("read byte on rejected insert");

endmodule

bind gap_buffer_text_store_core gbts_checker u_gbts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_char_out    (rsp.char_out),
    .rsp_cursor      (rsp.cursor),
    .rsp_text_length (rsp.text_length),
    .rsp_status      (rsp.status)
);

`default_nettype wire
